// ===== rtl/core/scd_pkg.sv =====
// Shared widths, register indexes, reset values and handshake structs of the SCReLU output block.
package scd_pkg;

  localparam int unsigned CLIP_W   = 15;
  localparam int unsigned WSCALE_W = 15;
  localparam int unsigned ESCALE_W = 13;
  localparam int unsigned BIAS_W   = 16;
  localparam int unsigned VAL_W    = 16;
  localparam int unsigned ACC_W    = 32;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Depth of the queue of finished sums; a power of two so that pointers wrap.
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] CFG_CLIP   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WSCALE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ESCALE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS   = 2'd3;

  localparam logic [CLIP_W-1:0]   CLIP_RST   = 15'd255;
  localparam logic [WSCALE_W-1:0] WSCALE_RST = 15'd64;
  localparam logic [ESCALE_W-1:0] ESCALE_RST = 13'd400;
  localparam logic [BIAS_W-1:0]   BIAS_RST   = 16'd0;

  typedef struct packed {
    logic             start;
    logic [ACC_W-1:0] dividend;
    logic [ACC_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [ACC_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== rtl/core/scd_front.sv =====
// Front end: clips the element pair, forms both SCReLU terms and keeps the running sum.
module scd_front import scd_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_push,
  output logic                     in_full,
  input  logic                     in_side_to_move,
  input  logic signed [VAL_W-1:0]  in_white_value,
  input  logic signed [VAL_W-1:0]  in_black_value,
  input  logic signed [VAL_W-1:0]  in_weight_own,
  input  logic signed [VAL_W-1:0]  in_weight_other,
  input  logic                     in_last,
  input  logic [CLIP_W-1:0]        clip_limit,
  input  logic [QCNT_W-1:0]        q_count,
  output logic                     q_push,
  output logic [ACC_W-1:0]         q_wdata
);

  function automatic logic [CLIP_W-1:0] clip_val(logic signed [VAL_W-1:0] v,
                                                 logic [CLIP_W-1:0] lim);
    logic [CLIP_W-1:0] res;
    if (v[VAL_W-1]) begin
      res = '0;
    end else if (v[CLIP_W-1:0] > lim) begin
      res = lim;
    end else begin
      res = v[CLIP_W-1:0];
    end
    return res;
  endfunction

  logic                     accept;
  logic signed [VAL_W-1:0]  own_val;
  logic signed [VAL_W-1:0]  oth_val;
  logic [CLIP_W-1:0]        va_c;
  logic [CLIP_W-1:0]        vb_c;
  logic signed [ACC_W-1:0]  pa_c;
  logic signed [ACC_W-1:0]  pb_c;
  logic signed [ACC_W-1:0]  ta_c;
  logic signed [ACC_W-1:0]  tb_c;
  logic [ACC_W-1:0]         sum_nxt;
  logic [QCNT_W:0]          occ;

  logic                     s1_vld_r;
  logic                     s1_last_r;
  logic [CLIP_W-1:0]        s1_va_r;
  logic [CLIP_W-1:0]        s1_vb_r;
  logic [VAL_W-1:0]         s1_pa_r;
  logic [VAL_W-1:0]         s1_pb_r;
  logic                     s2_vld_r;
  logic                     s2_last_r;
  logic [ACC_W-1:0]         s2_ta_r;
  logic [ACC_W-1:0]         s2_tb_r;
  logic [ACC_W-1:0]         sum_r;

  assign accept  = in_push && !in_full;
  assign own_val = in_side_to_move ? in_black_value : in_white_value;
  assign oth_val = in_side_to_move ? in_white_value : in_black_value;
  assign va_c    = clip_val(own_val, clip_limit);
  assign vb_c    = clip_val(oth_val, clip_limit);
  assign pa_c    = $signed({1'b0, va_c}) * in_weight_own;
  assign pb_c    = $signed({1'b0, vb_c}) * in_weight_other;

  // Only the low half of the first product is kept, read back as signed.
  assign ta_c    = $signed({1'b0, s1_va_r}) * $signed(s1_pa_r);
  assign tb_c    = $signed({1'b0, s1_vb_r}) * $signed(s1_pb_r);

  assign sum_nxt = sum_r + s2_ta_r + s2_tb_r;
  assign q_push  = s2_vld_r && s2_last_r;
  assign q_wdata = sum_nxt;

  // Reserve a queue slot for every last word still in the pipeline.
  assign occ = (QCNT_W+1)'(q_count) + (QCNT_W+1)'(s1_vld_r && s1_last_r)
             + (QCNT_W+1)'(s2_vld_r && s2_last_r);
  assign in_full = (occ >= (QCNT_W+1)'(QDEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s1_last_r <= 1'b0;
      s2_vld_r  <= 1'b0;
      s2_last_r <= 1'b0;
      sum_r     <= '0;
    end else begin
      s1_vld_r  <= accept;
      s1_last_r <= in_last;
      s2_vld_r  <= s1_vld_r;
      s2_last_r <= s1_last_r;
      if (s2_vld_r) begin
        sum_r <= s2_last_r ? '0 : sum_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_va_r <= va_c;
    s1_vb_r <= vb_c;
    s1_pa_r <= pa_c[VAL_W-1:0];
    s1_pb_r <= pb_c[VAL_W-1:0];
    s2_ta_r <= ta_c;
    s2_tb_r <= tb_c;
  end

  a_sum_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_vld_r && s2_last_r) |=> (sum_r == '0))
    else $error("running sum not cleared after a last word");

endmodule

// ===== rtl/core/scd_fifo.sv =====
// Short queue of finished sums between the front end and the output arithmetic.
module scd_fifo import scd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [ACC_W-1:0]  wdata,
  input  logic              pop,
  output logic [ACC_W-1:0]  rdata,
  output logic              empty,
  output logic [QCNT_W-1:0] count
);

  logic [ACC_W-1:0]  mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;

  assign rdata = mem_r[rd_ptr_r];
  assign empty = (cnt_r == '0);
  assign count = cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + QCNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (cnt_r != QCNT_W'(QDEPTH) || pop))
    else $error("sum queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (cnt_r != '0))
    else $error("sum queue read while empty");

endmodule

// ===== rtl/core/scd_div.sv =====
// Signed truncating 32-bit divider, one quotient bit per cycle; a zero divisor gives zero.
module scd_div import scd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int unsigned CNT_W = $clog2(ACC_W);

  logic [ACC_W-1:0] nmag;
  logic [ACC_W-1:0] dmag;
  logic [ACC_W:0]   shifted;
  logic [ACC_W:0]   diff;

  logic             busy_r;
  logic             fix_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [ACC_W-1:0] rem_r;
  logic [ACC_W-1:0] quo_r;
  logic [ACC_W-1:0] dvs_r;
  logic             neg_r;
  logic             zero_r;
  logic [ACC_W-1:0] res_r;

  assign nmag = req.dividend[ACC_W-1] ? (~req.dividend + ACC_W'(1)) : req.dividend;
  assign dmag = req.divisor[ACC_W-1]  ? (~req.divisor + ACC_W'(1))  : req.divisor;

  // Remainder stays below the divisor magnitude, so the shifted value fits 33 bits.
  assign shifted = {rem_r, quo_r[ACC_W-1]};
  assign diff    = shifted - {1'b0, dvs_r};

  assign rsp.busy     = busy_r || fix_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fix_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= fix_r;
      fix_r  <= busy_r && (cnt_r == CNT_W'(ACC_W - 1));
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(ACC_W - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r  <= '0;
      quo_r  <= nmag;
      dvs_r  <= dmag;
      neg_r  <= req.dividend[ACC_W-1] ^ req.divisor[ACC_W-1];
      zero_r <= (req.divisor == '0);
    end else if (busy_r) begin
      if (!diff[ACC_W]) begin
        rem_r <= diff[ACC_W-1:0];
        quo_r <= {quo_r[ACC_W-2:0], 1'b1};
      end else begin
        rem_r <= shifted[ACC_W-1:0];
        quo_r <= {quo_r[ACC_W-2:0], 1'b0};
      end
    end
    if (fix_r) begin
      if (zero_r) begin
        res_r <= '0;
      end else begin
        res_r <= neg_r ? (~quo_r + ACC_W'(1)) : quo_r;
      end
    end
  end

endmodule

// ===== rtl/core/scd_back.sv =====
// Back end: turns each finished sum into an evaluation and holds it in the output register.
module scd_back import scd_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  logic [ACC_W-1:0]    q_rdata,
  output logic                q_pop,
  input  logic [CLIP_W-1:0]   clip_limit,
  input  logic [WSCALE_W-1:0] weight_scale,
  input  logic [ESCALE_W-1:0] eval_mult,
  input  logic [BIAS_W-1:0]   output_bias,
  output div_req_t            div_req,
  input  div_rsp_t            div_rsp,
  output logic                out_empty,
  output logic [ACC_W-1:0]    out_evaluation,
  input  logic                out_pop
);

  localparam int unsigned DVS_W = CLIP_W + WSCALE_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIV1  = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_DIV2S = 3'd3;
  localparam logic [2:0] ST_DIV2  = 3'd4;
  localparam logic [2:0] ST_FIN   = 3'd5;

  logic [2:0]       state_r;
  logic [2:0]       state_nxt;
  logic [ACC_W-1:0] dvs_r;
  logic [ACC_W-1:0] acc_r;
  logic [ACC_W-1:0] res_r;
  logic             out_vld_r;
  logic [ACC_W-1:0] out_data_r;
  logic [DVS_W-1:0] dvs_c;
  logic             start_job;
  logic             out_free;

  assign dvs_c = {{WSCALE_W{1'b0}}, clip_limit} * {{CLIP_W{1'b0}}, weight_scale};

  assign start_job = (state_r == ST_IDLE) && !q_empty && !div_rsp.busy;
  assign out_free  = !out_vld_r || out_pop;
  assign q_pop     = start_job;

  assign div_req.start    = start_job || (state_r == ST_DIV2S);
  assign div_req.dividend = (state_r == ST_IDLE) ? q_rdata : acc_r;
  assign div_req.divisor  = (state_r == ST_IDLE) ?
                            {{(ACC_W-CLIP_W){1'b0}}, clip_limit} : dvs_r;

  assign out_empty      = !out_vld_r;
  assign out_evaluation = out_data_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start_job) begin
          state_nxt = ST_DIV1;
        end
      end
      ST_DIV1: begin
        if (div_rsp.done) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL:   state_nxt = ST_DIV2S;
      ST_DIV2S: state_nxt = ST_DIV2;
      ST_DIV2: begin
        if (div_rsp.done) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == ST_FIN) && out_free) begin
        out_vld_r <= 1'b1;
      end else if (out_pop) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_job) begin
      dvs_r <= ACC_W'(dvs_c);
    end
    if ((state_r == ST_DIV1) && div_rsp.done) begin
      acc_r <= div_rsp.quotient + {{(ACC_W-BIAS_W){output_bias[BIAS_W-1]}}, output_bias};
    end else if (state_r == ST_MUL) begin
      acc_r <= acc_r * {{(ACC_W-ESCALE_W){1'b0}}, eval_mult};
    end
    if ((state_r == ST_DIV2) && div_rsp.done) begin
      res_r <= div_rsp.quotient;
    end
    if ((state_r == ST_FIN) && out_free) begin
      out_data_r <= res_r;
    end
  end

  a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while still busy");

endmodule

// ===== rtl/core/screlu_dot_product_output_top.sv =====
// Top level of the SCReLU output layer: configuration registers and the front, queue, divider and back.
//
//   Channel | Ports                                           | Handshake
//   input   | in_side_to_move, in_*_value, in_weight_*, in_last | in_push / in_full
//   result  | out_evaluation                                  | out_pop / out_empty
//   config  | cfg_index, cfg_wdata                            | cfg_we, no wait
//
// The front end takes one word per cycle while in_full is low; a word passes through the
// s1 and s2 pipeline registers before it enters the running sum.
// Each last word leaves a sum in a four-entry queue; the back end takes one sum at a time
// and makes two passes through the bit-serial 32-bit divider for it.
// in_full rises while the queue, counting last words still in the front pipeline, is full.
// Reset clears the sum, the pipeline, the queue and the output valid flag, and reloads the
// configuration registers with their defaults.
module screlu_dot_product_output_top import scd_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_push,
  output logic                    in_full,
  input  logic                    in_side_to_move,
  input  logic signed [VAL_W-1:0] in_white_value,
  input  logic signed [VAL_W-1:0] in_black_value,
  input  logic signed [VAL_W-1:0] in_weight_own,
  input  logic signed [VAL_W-1:0] in_weight_other,
  input  logic                    in_last,
  output logic                    out_empty,
  input  logic                    out_pop,
  output logic signed [ACC_W-1:0] out_evaluation,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata
);

  logic [CLIP_W-1:0]   clip_r;
  logic [WSCALE_W-1:0] wscale_r;
  logic [ESCALE_W-1:0] escale_r;
  logic [BIAS_W-1:0]   bias_r;

  logic              q_push;
  logic [ACC_W-1:0]  q_wdata;
  logic              q_pop;
  logic [ACC_W-1:0]  q_rdata;
  logic              q_empty;
  logic [QCNT_W-1:0] q_count;
  div_req_t          div_req;
  div_rsp_t          div_rsp;
  logic [ACC_W-1:0]  eval_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_r   <= CLIP_RST;
      wscale_r <= WSCALE_RST;
      escale_r <= ESCALE_RST;
      bias_r   <= BIAS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CLIP:   clip_r   <= cfg_wdata[CLIP_W-1:0];
        CFG_WSCALE: wscale_r <= cfg_wdata[WSCALE_W-1:0];
        CFG_ESCALE: escale_r <= cfg_wdata[ESCALE_W-1:0];
        CFG_BIAS:   bias_r   <= cfg_wdata[BIAS_W-1:0];
        default:    bias_r   <= bias_r;
      endcase
    end
  end

  scd_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_side_to_move (in_side_to_move),
    .in_white_value  (in_white_value),
    .in_black_value  (in_black_value),
    .in_weight_own   (in_weight_own),
    .in_weight_other (in_weight_other),
    .in_last         (in_last),
    .clip_limit      (clip_r),
    .q_count         (q_count),
    .q_push          (q_push),
    .q_wdata         (q_wdata)
  );

  scd_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty),
    .count (q_count)
  );

  scd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  scd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_rdata        (q_rdata),
    .q_pop          (q_pop),
    .clip_limit     (clip_r),
    .weight_scale   (wscale_r),
    .eval_mult      (escale_r),
    .output_bias    (bias_r),
    .div_req        (div_req),
    .div_rsp        (div_rsp),
    .out_empty      (out_empty),
    .out_evaluation (eval_w),
    .out_pop        (out_pop)
  );

  assign out_evaluation = $signed(eval_w);

endmodule
